// ----- src/pstl_pkg.sv -----
// Package for the packed sorted key table lookup core.
// Holds store sizes, field width limits, request and status codes and the state type.
// Used by pstl_store and packed_sorted_key_table_lookup_core.
package pstl_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int STORE_WORDS = 1792;
    localparam int WORD_BITS   = 64;
    localparam int ADDR_BITS   = $clog2(STORE_WORDS);
    localparam int WIN_WORDS   = 3;
    localparam int WIN_BITS    = WIN_WORDS * WORD_BITS;
    localparam int BASE_BITS   = 17;

    localparam logic [5:0] KEY_MAX_W = 6'd32;
    localparam logic [5:0] OFS_MAX_W = 6'd48;
    localparam logic [5:0] LEN_MAX_W = 6'd32;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    localparam logic [1:0] CFG_KEY_W = 2'd0;
    localparam logic [1:0] CFG_OFS_W = 2'd1;
    localparam logic [1:0] CFG_LEN_W = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SRCH = 8'b0000_0010,
        S_BASE = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_WAIT = 8'b0001_0000,
        S_EVAL = 8'b0010_0000,
        S_WR   = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

endpackage

// ----- src/packed_sorted_key_table_lookup_core.sv -----
// Top level of the packed sorted key table lookup core: sequencer, shared field unit, ports.
// Depends on pstl_pkg and pstl_store.
//
//  channel   dir  tdata                                       tuser
//  s_        in   position, key, offset, length (128 bits)    req_type
//  m_        out  found_key, found_offset, found_length       status
//  cfg_      in   write enable, index, data                   -
//
// Each record access reads three store words, one at a time through the single read port.
// A read passes the base, read, wait and evaluate states before its result shows; a load
// also writes its three words back. A lookup does a search step and a record access per
// halving of the entry count plus one final probe. Reset is synchronous; the store contents
// are undefined until written. The block takes no word until its result has been taken.
module packed_sorted_key_table_lookup_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // position, key, offset, length, zero fill
    input  logic [1:0]    s_tuser,   // req_type
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // found_key, found_offset, found_length
    output logic [1:0]    m_tuser,   // status
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [10:0]   cfg_data
);

    localparam int AW = pstl_pkg::ADDR_BITS;
    localparam int WB = pstl_pkg::WORD_BITS;
    localparam int NB = pstl_pkg::WIN_BITS;
    localparam int BB = pstl_pkg::BASE_BITS;

    pstl_pkg::state_t state_reg;
    logic [5:0]  key_w_reg, ofs_w_reg, len_w_reg;
    logic [10:0] count_reg;
    logic [1:0]  req_reg;
    logic [31:0] key_reg;
    logic [47:0] ofs_reg;
    logic [31:0] len_reg;
    logic [9:0]  idx_reg;
    logic [10:0] beg_reg, end_reg;
    logic        final_reg;
    logic [BB-1:0] base_reg;
    logic [1:0]  cnt_reg;
    logic        rvld_reg, rok_reg;
    logic [1:0]  rslot_reg;
    logic [NB-1:0] win_reg;
    logic [1:0]  ost_reg;
    logic [31:0] okey_reg;
    logic [47:0] oofs_reg;
    logic [31:0] olen_reg;

    logic [5:0]  kw, ow, lw;
    logic [6:0]  rlen;
    logic [10:0] n;
    logic [11:0] mid_sum;
    logic [10:0] mid;
    logic [11:0] word_sum;
    logic        word_ok;
    logic [31:0] kmask, lmask;
    logic [47:0] omask;
    logic [NB-1:0] sh, sh2, sh3, ins, rmask, newwin;
    logic [31:0] fk, fl;
    logic [47:0] fo;
    logic [WB-1:0] rd_data;
    logic [9:0]  in_pos;
    logic [31:0] in_key, in_len;
    logic [47:0] in_ofs;

    assign in_pos = s_tdata[9:0];
    assign in_key = s_tdata[41:10];
    assign in_ofs = s_tdata[89:42];
    assign in_len = s_tdata[121:90];

    assign kw = (key_w_reg > pstl_pkg::KEY_MAX_W) ? pstl_pkg::KEY_MAX_W : key_w_reg;
    assign ow = (ofs_w_reg > pstl_pkg::OFS_MAX_W) ? pstl_pkg::OFS_MAX_W : ofs_w_reg;
    assign lw = (len_w_reg > pstl_pkg::LEN_MAX_W) ? pstl_pkg::LEN_MAX_W : len_w_reg;
    assign rlen = 7'(kw) + 7'(ow) + 7'(lw);
    assign n = (count_reg > 11'(pstl_pkg::MAX_ENTRIES)) ? 11'(pstl_pkg::MAX_ENTRIES)
                                                        : count_reg;

    assign mid_sum = 12'(beg_reg) + 12'(end_reg);
    assign mid = mid_sum[11:1];

    assign word_sum = 12'(base_reg[BB-1:6]) + 12'(cnt_reg);
    assign word_ok = word_sum < 12'(pstl_pkg::STORE_WORDS);

    assign kmask = 32'((64'd1 << kw) - 64'd1);
    assign omask = 48'((64'd1 << ow) - 64'd1);
    assign lmask = 32'((64'd1 << lw) - 64'd1);

    assign sh  = win_reg >> base_reg[5:0];
    assign sh2 = sh >> kw;
    assign sh3 = sh >> (7'(kw) + 7'(ow));
    assign fk = sh[31:0] & kmask;
    assign fo = sh2[47:0] & omask;
    assign fl = sh3[31:0] & lmask;

    assign ins = ((NB'(len_reg & lmask) << (7'(kw) + 7'(ow)))
                 | (NB'(ofs_reg & omask) << kw)
                 | NB'(key_reg & kmask)) << base_reg[5:0];
    assign rmask = ((NB'(1) << rlen) - NB'(1)) << base_reg[5:0];
    assign newwin = (win_reg & ~rmask) | ins;

    pstl_store u_store (
        .aclk    (aclk),
        .wr_en   ((state_reg == pstl_pkg::S_WR) && word_ok),
        .wr_addr (word_sum[AW-1:0]),
        .wr_data (win_reg[cnt_reg*WB +: WB]),
        .rd_addr (word_sum[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_w_reg <= pstl_pkg::KEY_MAX_W;
            ofs_w_reg <= pstl_pkg::OFS_MAX_W;
            len_w_reg <= pstl_pkg::LEN_MAX_W;
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pstl_pkg::CFG_KEY_W: key_w_reg <= cfg_data[5:0];
                pstl_pkg::CFG_OFS_W: ofs_w_reg <= cfg_data[5:0];
                pstl_pkg::CFG_LEN_W: len_w_reg <= cfg_data[5:0];
                pstl_pkg::CFG_COUNT: count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rvld_reg <= (state_reg == pstl_pkg::S_RD);
        rok_reg <= word_ok;
        rslot_reg <= cnt_reg;
        if (rvld_reg) begin
            win_reg[rslot_reg*WB +: WB] <= rok_reg ? rd_data : '0;
        end else if (state_reg == pstl_pkg::S_EVAL) begin
            win_reg <= newwin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pstl_pkg::S_IDLE;
            cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                pstl_pkg::S_IDLE: begin
                    if (s_tvalid) begin
                        req_reg <= s_tuser;
                        key_reg <= in_key;
                        ofs_reg <= in_ofs;
                        len_reg <= in_len;
                        idx_reg <= in_pos;
                        beg_reg <= '0;
                        end_reg <= n;
                        final_reg <= 1'b0;
                        ost_reg <= pstl_pkg::ST_RANGE;
                        okey_reg <= '1;
                        oofs_reg <= '1;
                        olen_reg <= '1;
                        if (s_tuser == pstl_pkg::REQ_LOOKUP) begin
                            state_reg <= pstl_pkg::S_SRCH;
                        end else if (s_tuser == pstl_pkg::REQ_LOAD ||
                                     s_tuser == pstl_pkg::REQ_READ) begin
                            state_reg <= (11'(in_pos) >= n) ? pstl_pkg::S_OUT
                                                            : pstl_pkg::S_BASE;
                        end
                    end
                end
                pstl_pkg::S_SRCH: begin
                    if (12'(beg_reg) + 12'd1 < 12'(end_reg)) begin
                        idx_reg <= mid[9:0];
                        state_reg <= pstl_pkg::S_BASE;
                    end else if (beg_reg >= end_reg) begin
                        ost_reg <= pstl_pkg::ST_NOT_FOUND;
                        state_reg <= pstl_pkg::S_OUT;
                    end else begin
                        idx_reg <= beg_reg[9:0];
                        final_reg <= 1'b1;
                        state_reg <= pstl_pkg::S_BASE;
                    end
                end
                pstl_pkg::S_BASE: begin
                    base_reg <= BB'(idx_reg) * BB'(rlen);
                    cnt_reg <= '0;
                    state_reg <= pstl_pkg::S_RD;
                end
                pstl_pkg::S_RD: begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'(pstl_pkg::WIN_WORDS - 1)) begin
                        state_reg <= pstl_pkg::S_WAIT;
                    end
                end
                pstl_pkg::S_WAIT: begin
                    state_reg <= pstl_pkg::S_EVAL;
                end
                pstl_pkg::S_EVAL: begin
                    cnt_reg <= '0;
                    if (req_reg == pstl_pkg::REQ_LOAD) begin
                        ost_reg <= pstl_pkg::ST_OK;
                        okey_reg <= key_reg & kmask;
                        oofs_reg <= ofs_reg & omask;
                        olen_reg <= len_reg & lmask;
                        state_reg <= pstl_pkg::S_WR;
                    end else if (req_reg == pstl_pkg::REQ_READ ||
                                 (final_reg && fk == key_reg)) begin
                        ost_reg <= pstl_pkg::ST_OK;
                        okey_reg <= fk;
                        oofs_reg <= fo;
                        olen_reg <= fl;
                        state_reg <= pstl_pkg::S_OUT;
                    end else if (final_reg) begin
                        ost_reg <= pstl_pkg::ST_NOT_FOUND;
                        state_reg <= pstl_pkg::S_OUT;
                    end else begin
                        if (key_reg < fk) begin
                            end_reg <= 11'(idx_reg);
                        end else begin
                            beg_reg <= 11'(idx_reg);
                        end
                        state_reg <= pstl_pkg::S_SRCH;
                    end
                end
                pstl_pkg::S_WR: begin
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'(pstl_pkg::WIN_WORDS - 1)) begin
                        state_reg <= pstl_pkg::S_OUT;
                    end
                end
                pstl_pkg::S_OUT: begin
                    if (m_tready) begin
                        state_reg <= pstl_pkg::S_IDLE;
                    end
                end
                default: state_reg <= pstl_pkg::S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == pstl_pkg::S_IDLE);
    assign m_tvalid = (state_reg == pstl_pkg::S_OUT);
    assign m_tdata = {olen_reg, oofs_reg, okey_reg};
    assign m_tuser = ost_reg;

endmodule

// ----- src/pstl_store.sv -----
// Packed word store of the lookup core: one write port and one registered read port.
// Depends on pstl_pkg for the depth and word width.
module pstl_store (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [pstl_pkg::ADDR_BITS-1:0]  wr_addr,
    input  logic [pstl_pkg::WORD_BITS-1:0]  wr_data,
    input  logic [pstl_pkg::ADDR_BITS-1:0]  rd_addr,
    output logic [pstl_pkg::WORD_BITS-1:0]  rd_data
);

    logic [pstl_pkg::WORD_BITS-1:0] mem_q [pstl_pkg::STORE_WORDS];
    logic [pstl_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_q[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
